// File: hdl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, switched off during reset.
`define SBT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Implication checked in the cycle after the antecedent, switched off during reset.
`define SBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/sbt_pkg.sv
// Types and constants shared by the stereo blob triangulation modules.
package sbt_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROUND = 2'd1,
    ST_NEG_DISP = 2'd2,
    ST_TOO_FAR  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_FOCAL_X    = 3'd0,
    CFG_FOCAL_Y    = 3'd1,
    CFG_CENTER_X   = 3'd2,
    CFG_CENTER_Y   = 3'd3,
    CFG_BASELINE   = 3'd4,
    CFG_MOUNT_H    = 3'd5,
    CFG_DEPTH_LIM  = 3'd6,
    CFG_ASPECT_TOL = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_MUL,
    BK_CHK,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [15:0] focal_x_q8;
    logic [15:0] focal_y_q8;
    logic [8:0]  center_x;
    logic [7:0]  center_y;
    logic [15:0] baseline_q4;
    logic [11:0] mount_height_mm;
    logic [11:0] depth_limit_mm;
    logic [8:0]  aspect_tol_q8;
  } cfg_t;

  typedef struct packed {
    logic       left_found;
    logic       right_found;
    logic [8:0] left_x;
    logic [7:0] left_y;
    logic [8:0] right_x;
    logic [7:0] right_y;
  } job_t;

  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] RST_FOCAL_X    = 16'd56000;
  localparam logic [15:0] RST_FOCAL_Y    = 16'd53760;
  localparam logic [8:0]  RST_CENTER_X   = 9'd160;
  localparam logic [7:0]  RST_CENTER_Y   = 8'd92;
  localparam logic [15:0] RST_BASELINE   = 16'd3454;
  localparam logic [11:0] RST_MOUNT_H    = 12'd260;
  localparam logic [11:0] RST_DEPTH_LIM  = 12'd2000;
  localparam logic [8:0]  RST_ASPECT_TOL = 9'd256;

  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 26;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

endpackage

// File: hdl/sbt_front.sv
// Front end: roundness test, per-camera blob capture and job hand-off at frame end.
module sbt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          camera_id_i,
  input  logic [8:0]    blob_x_i,
  input  logic [7:0]    blob_y_i,
  input  logic [8:0]    blob_width_i,
  input  logic [7:0]    blob_height_i,
  input  logic          frame_end_i,
  input  logic [8:0]    aspect_tol_i,
  input  logic          full_i,
  output logic          push_o,
  output sbt_pkg::job_t job_o
);

  logic              lf_q, rf_q;
  logic [8:0]        lx_q, rx_q;
  logic [7:0]        ly_q, ry_q;
  logic signed [10:0] lo_f, hi_f;
  logic signed [20:0] w21, h21, lo_p, hi_p;
  logic              round, accept, take_l, take_r;

  // Bounds are w*(256-tol) and w*(256+tol); a large tolerance drives the lower one negative.
  assign lo_f = 11'sd256 - $signed({2'b00, aspect_tol_i});
  assign hi_f = 11'sd256 + $signed({2'b00, aspect_tol_i});
  assign w21  = $signed({12'd0, blob_width_i});
  assign h21  = $signed({5'd0, blob_height_i, 8'd0});
  assign lo_p = w21 * $signed({{10{lo_f[10]}}, lo_f});
  assign hi_p = w21 * $signed({{10{hi_f[10]}}, hi_f});
  assign round = (lo_p < h21) && (h21 < hi_p);

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign take_l     = round && !camera_id_i && !lf_q;
  assign take_r     = round && camera_id_i && !rf_q;
  assign push_o     = accept && frame_end_i;

  always_comb begin
    job_o.left_found  = lf_q || take_l;
    job_o.right_found = rf_q || take_r;
    job_o.left_x      = take_l ? blob_x_i : lx_q;
    job_o.left_y      = take_l ? blob_y_i : ly_q;
    job_o.right_x     = take_r ? blob_x_i : rx_q;
    job_o.right_y     = take_r ? blob_y_i : ry_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_q <= 1'b0;
      rf_q <= 1'b0;
      lx_q <= '0;
      ly_q <= '0;
      rx_q <= '0;
      ry_q <= '0;
    end else if (accept) begin
      if (frame_end_i) begin
        lf_q <= 1'b0;
        rf_q <= 1'b0;
        lx_q <= '0;
        ly_q <= '0;
        rx_q <= '0;
        ry_q <= '0;
      end else begin
        if (take_l) begin
          lf_q <= 1'b1;
          lx_q <= blob_x_i;
          ly_q <= blob_y_i;
        end
        if (take_r) begin
          rf_q <= 1'b1;
          rx_q <= blob_x_i;
          ry_q <= blob_y_i;
        end
      end
    end
  end

endmodule

// File: hdl/sbt_queue.sv
// Two-entry job queue between the front end and the arithmetic back end.
module sbt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sbt_pkg::job_t job_i,
  input  logic          pop_i,
  output sbt_pkg::job_t job_o,
  output logic          empty_o,
  output logic          full_o
);

  sbt_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: hdl/sbt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sbt_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sbt_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [sbt_pkg::DIV_DEN_W-1:0]  den_i,
  output logic                           done_o,
  output logic [sbt_pkg::DIV_NUM_W-1:0]  quo_o
);

  logic                          busy_q, done_q;
  logic [sbt_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [sbt_pkg::DIV_DEN_W-1:0] rem_q, den_q, rem_d;
  logic [sbt_pkg::DIV_NUM_W-1:0] nq_q;
  logic [sbt_pkg::DIV_DEN_W:0]   trial;
  logic                          ge;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign trial = {rem_q, nq_q[sbt_pkg::DIV_NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? sbt_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
                    : trial[sbt_pkg::DIV_DEN_W-1:0];
  assign done_o = done_q;
  assign quo_o  = nq_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      nq_q  <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      nq_q  <= {nq_q[sbt_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == sbt_pkg::DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/sbt_back.sv
// Back end: disparity checks, depth and position arithmetic, result register.
module sbt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sbt_pkg::cfg_t         cfg_i,
  input  logic                  empty_i,
  input  sbt_pkg::job_t         job_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic signed [20:0]    world_x_q4_o,
  output logic signed [20:0]    world_y_q4_o,
  output logic [15:0]           world_z_q4_o
);

  sbt_pkg::back_state_e state_q, state_d;
  sbt_pkg::job_t        j_q;
  sbt_pkg::status_e     st_q, st_c;

  logic signed [10:0] d_q;
  logic signed [11:0] sx_q;
  logic signed [10:0] sy_q;
  logic [31:0]        p_q;
  logic [15:0]        fy_q;
  logic [20:0]        lim_q;
  logic [25:0]        sxb_q, deny_q;
  logic [40:0]        syp_q;
  logic [9:0]         sx_mag;
  logic [8:0]         sy_mag;

  logic        div_start, div_done, done_z, done_x, done_y;
  logic [40:0] qz, qx, qy;

  logic        out_free, out_load, out_valid_q;
  logic [1:0]  status_q;
  logic signed [20:0] wx_q, wy_q;
  logic [15:0] wz_q;
  logic signed [41:0] vx;
  logic signed [43:0] vy;
  logic signed [20:0] wx_c, wy_c;
  logic [15:0] wz_c;

  assign sx_mag = sx_q[11] ? 10'(-sx_q) : sx_q[9:0];
  assign sy_mag = sy_q[10] ? 9'(-sy_q) : sy_q[8:0];

  // Depth is rejected when disparity is zero or focal*baseline exceeds limit*4096*disparity.
  always_comb begin
    if (!j_q.left_found || !j_q.right_found) begin
      st_c = sbt_pkg::ST_NO_ROUND;
    end else if (d_q < 0) begin
      st_c = sbt_pkg::ST_NEG_DISP;
    end else if (d_q == 0 || {1'b0, p_q} > {lim_q, 12'd0}) begin
      st_c = sbt_pkg::ST_TOO_FAR;
    end else begin
      st_c = sbt_pkg::ST_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbt_pkg::BK_IDLE: if (!empty_i) state_d = sbt_pkg::BK_PREP;
      sbt_pkg::BK_PREP: state_d = sbt_pkg::BK_MUL;
      sbt_pkg::BK_MUL:  state_d = sbt_pkg::BK_CHK;
      sbt_pkg::BK_CHK: begin
        state_d = (st_c == sbt_pkg::ST_OK) ? sbt_pkg::BK_DIV : sbt_pkg::BK_DONE;
      end
      sbt_pkg::BK_DIV:  if (div_done) state_d = sbt_pkg::BK_DONE;
      sbt_pkg::BK_DONE: if (out_free) state_d = sbt_pkg::BK_IDLE;
      default:          state_d = sbt_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      sbt_pkg::BK_IDLE: pop_o = !empty_i;
      sbt_pkg::BK_CHK:  div_start = (st_c == sbt_pkg::ST_OK);
      sbt_pkg::BK_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbt_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      j_q <= job_i;
    end
    if (state_q == sbt_pkg::BK_PREP) begin
      d_q  <= $signed({2'b00, j_q.left_x}) - $signed({2'b00, j_q.right_x});
      sx_q <= $signed({3'b000, j_q.left_x}) + $signed({3'b000, j_q.right_x})
              - $signed({2'b00, cfg_i.center_x, 1'b0});
      sy_q <= $signed({3'b000, j_q.left_y}) + $signed({3'b000, j_q.right_y})
              - $signed({2'b00, cfg_i.center_y, 1'b0});
      p_q  <= 32'(cfg_i.focal_x_q8 * cfg_i.baseline_q4);
      fy_q <= (cfg_i.focal_y_q8 == 16'd0) ? 16'd1 : cfg_i.focal_y_q8;
    end
    if (state_q == sbt_pkg::BK_MUL) begin
      lim_q  <= 21'(cfg_i.depth_limit_mm * d_q[8:0]);
      sxb_q  <= 26'(sx_mag * cfg_i.baseline_q4);
      syp_q  <= 41'(sy_mag * p_q);
      deny_q <= 26'({d_q[8:0], 1'b0} * fy_q);
    end
    if (state_q == sbt_pkg::BK_CHK) begin
      st_q <= st_c;
    end
  end

  sbt_div u_div_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({17'd0, p_q[31:8]}),
    .den_i  ({17'd0, d_q[8:0]}),
    .done_o (done_z),
    .quo_o  (qz)
  );

  sbt_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({15'd0, sxb_q}),
    .den_i  ({16'd0, d_q[8:0], 1'b0}),
    .done_o (done_x),
    .quo_o  (qx)
  );

  sbt_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (syp_q),
    .den_i  (deny_q),
    .done_o (done_y),
    .quo_o  (qy)
  );

  assign div_done = done_z && done_x && done_y;

  // Quotients are magnitudes; the signs of the pixel sums are put back here.
  always_comb begin
    wz_c = (qz > 41'd65535) ? 16'hFFFF : qz[15:0];
    vx   = sx_q[11] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    vy   = $signed({28'd0, cfg_i.mount_height_mm, 4'd0})
           - (sy_q[10] ? -$signed({3'b000, qy}) : $signed({3'b000, qy}));
    if (vx > 42'sd1048575) begin
      wx_c = 21'sd1048575;
    end else if (vx < -42'sd1048576) begin
      wx_c = -21'sd1048576;
    end else begin
      wx_c = vx[20:0];
    end
    if (vy > 44'sd1048575) begin
      wy_c = 21'sd1048575;
    end else if (vy < -44'sd1048576) begin
      wy_c = -21'sd1048576;
    end else begin
      wy_c = vy[20:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= st_q;
      if (st_q == sbt_pkg::ST_OK) begin
        wx_q <= wx_c;
        wy_q <= wy_c;
        wz_q <= wz_c;
      end else begin
        wx_q <= '0;
        wy_q <= '0;
        wz_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign world_x_q4_o = wx_q;
  assign world_y_q4_o = wy_q;
  assign world_z_q4_o = wz_q;

endmodule

// File: hdl/stereo_blob_triangulation.sv
// Top level of the stereo blob triangulation block: configuration registers and wiring.
//
//   channel | direction | handshake               | beat
//   in      | input     | in_valid_i / in_stall_o   | one blob, camera tag, frame-end mark
//   out     | output    | out_valid_o / out_stall_i | status and world x, y, z
//   cfg     | input     | cfg_we_i                  | register index and data
//
// A blob without the frame-end mark is taken whenever the queue is not full. A frame-end
// beat walks the back-end states prep, mul, chk, div and done when a position is
// computed, div lasting until three 41-step restoring dividers that run side by side
// finish, and skips div when the frame is rejected; the two-entry queue lets the front
// keep taking blobs meanwhile until it fills. Reset is asynchronous and active low and
// clears all control state. A stalled result holds in the output register.
module stereo_blob_triangulation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           camera_id_i,
  input  logic [8:0]                     blob_x_i,
  input  logic [7:0]                     blob_y_i,
  input  logic [8:0]                     blob_width_i,
  input  logic [7:0]                     blob_height_i,
  input  logic                           frame_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     status_o,
  output logic signed [20:0]             world_x_q4_o,
  output logic signed [20:0]             world_y_q4_o,
  output logic [15:0]                    world_z_q4_o,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [sbt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sbt_pkg::cfg_t cfg_q;
  sbt_pkg::job_t push_job, pop_job;
  logic          push, pop, empty, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x_q8      <= sbt_pkg::RST_FOCAL_X;
      cfg_q.focal_y_q8      <= sbt_pkg::RST_FOCAL_Y;
      cfg_q.center_x        <= sbt_pkg::RST_CENTER_X;
      cfg_q.center_y        <= sbt_pkg::RST_CENTER_Y;
      cfg_q.baseline_q4     <= sbt_pkg::RST_BASELINE;
      cfg_q.mount_height_mm <= sbt_pkg::RST_MOUNT_H;
      cfg_q.depth_limit_mm  <= sbt_pkg::RST_DEPTH_LIM;
      cfg_q.aspect_tol_q8   <= sbt_pkg::RST_ASPECT_TOL;
    end else if (cfg_we_i) begin
      case (sbt_pkg::cfg_idx_e'(cfg_idx_i))
        sbt_pkg::CFG_FOCAL_X:    cfg_q.focal_x_q8      <= cfg_data_i;
        sbt_pkg::CFG_FOCAL_Y:    cfg_q.focal_y_q8      <= cfg_data_i;
        sbt_pkg::CFG_CENTER_X:   cfg_q.center_x        <= cfg_data_i[8:0];
        sbt_pkg::CFG_CENTER_Y:   cfg_q.center_y        <= cfg_data_i[7:0];
        sbt_pkg::CFG_BASELINE:   cfg_q.baseline_q4     <= cfg_data_i;
        sbt_pkg::CFG_MOUNT_H:    cfg_q.mount_height_mm <= cfg_data_i[11:0];
        sbt_pkg::CFG_DEPTH_LIM:  cfg_q.depth_limit_mm  <= cfg_data_i[11:0];
        sbt_pkg::CFG_ASPECT_TOL: cfg_q.aspect_tol_q8   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  sbt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .camera_id_i  (camera_id_i),
    .blob_x_i     (blob_x_i),
    .blob_y_i     (blob_y_i),
    .blob_width_i (blob_width_i),
    .blob_height_i(blob_height_i),
    .frame_end_i  (frame_end_i),
    .aspect_tol_i (cfg_q.aspect_tol_q8),
    .full_i       (full),
    .push_o       (push),
    .job_o        (push_job)
  );

  sbt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (pop_job),
    .empty_o(empty),
    .full_o (full)
  );

  sbt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .world_x_q4_o(world_x_q4_o),
    .world_y_q4_o(world_y_q4_o),
    .world_z_q4_o(world_z_q4_o)
  );

endmodule

// File: hdl/sbt_checker.sv
// Port-level checks for the stereo blob triangulation block, bound to the top level.
`include "assert_macros.svh"

module sbt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic [1:0]         status_i,
  input logic signed [20:0] world_x_q4_i,
  input logic signed [20:0] world_y_q4_i,
  input logic [15:0]        world_z_q4_i
);

  logic held, ok_beat, rej_beat, zero_pos;
  assign held     = out_valid_i && out_stall_i;
  assign ok_beat  = out_valid_i && status_i == sbt_pkg::ST_OK;
  assign rej_beat = out_valid_i && status_i != sbt_pkg::ST_OK;
  assign zero_pos = world_x_q4_i == 21'sd0 && world_y_q4_i == 21'sd0 && world_z_q4_i == 16'd0;

  `SBT_ASSERT_NEXT(a_out_valid_holds, held, out_valid_i)
  `SBT_ASSERT_NEXT(a_out_beat_holds, held, $stable(status_i) && $stable(world_z_q4_i))
  `SBT_ASSERT_NOW(a_reject_zero, rej_beat, zero_pos)
  // An accepted depth never exceeds sixteen times the largest depth limit.
  `SBT_ASSERT_NOW(a_depth_bound, ok_beat, world_z_q4_i <= 16'd65520)

endmodule

bind stereo_blob_triangulation sbt_checker u_sbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_i    (status_o),
  .world_x_q4_i(world_x_q4_o),
  .world_y_q4_i(world_y_q4_o),
  .world_z_q4_i(world_z_q4_o)
);
